// File: src/pni_pkg.sv
// Shared types, constants and helpers for the pixel noise injector.
// Used by pni_prng and prng_pixel_noise_injector; depends on nothing.

package pni_pkg;

   // Generator setup
   localparam logic [63:0] SeedMix            = 64'h6A09E667F3BCC908;
   localparam int          WarmupStepsDefault = 8;

   // xorshift128+ shift amounts
   localparam int ShiftA = 23;
   localparam int ShiftB = 17;
   localparam int ShiftC = 26;

   // Low bits of the group draw that must be zero for a noisy group leader
   localparam logic [2:0] GateMask = 3'h7;

   // Width of a draw folded by 2^16 == 1 (mod 3)
   localparam int FoldW = 18;

   // Commands from the sequencer to the generator
   typedef struct packed {
      logic seed;   // load words from the seed register
      logic step;   // advance one xorshift step and register the draw
   } prng_cmd_type;

   // Residue of a folded draw modulo 3 (4 == 1 mod 3, so 2-bit digits add up)
   function automatic logic [1:0] mod3_fold(input logic [FoldW-1:0] value);
      logic [4:0] digit_sum;
      logic [2:0] small_sum;
      logic [2:0] rem;
      digit_sum = '0;
      for (int i = 0; i < FoldW / 2; i++) begin
         digit_sum = digit_sum + 5'(value[2*i +: 2]);
      end
      small_sum = 3'(digit_sum[1:0]) + 3'(digit_sum[3:2]) + 3'(digit_sum[4]);
      if (small_sum >= 3'd6) begin
         rem = small_sum - 3'd6;
      end else if (small_sum >= 3'd3) begin
         rem = small_sum - 3'd3;
      end else begin
         rem = small_sum;
      end
      return rem[1:0];
   endfunction

endpackage

// File: src/pni_prng.sv
// xorshift128+ generator: two 64-bit state words and a registered draw.
// One step per cycle on command; depends on pni_pkg.

module pni_prng (
   input  logic                 clock,
   input  logic                 reset,
   input  pni_pkg::prng_cmd_type cmd,
   input  logic [63:0]          seed_value,
   output logic [63:0]          draw
);

   logic [63:0] first_ff,  first_in;
   logic [63:0] second_ff, second_in;
   logic [63:0] draw_ff,   draw_in;
   logic [63:0] mix;

   // One xorshift step on the current words
   always_comb begin
      mix = first_ff ^ (first_ff << pni_pkg::ShiftA);
      mix = mix ^ (mix >> pni_pkg::ShiftB);
      mix = mix ^ second_ff ^ (second_ff >> pni_pkg::ShiftC);
   end

   // Next-state select: seed, step or hold
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      draw_in   = draw_ff;
      if (cmd.seed) begin
         first_in  = seed_value;
         second_in = seed_value ^ pni_pkg::SeedMix;
      end else if (cmd.step) begin
         first_in  = second_ff;
         second_in = mix;
         draw_in   = second_ff + mix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
      draw_ff <= draw_in;
   end

   assign draw = draw_ff;

   // Sequencer never seeds and steps in the same cycle
   assert property (@(posedge clock) disable iff (reset) !(cmd.seed && cmd.step))
      else $error("pni_prng: seed and step together");

endmodule

// File: src/prng_pixel_noise_injector.sv
// Top level of the pixel noise injector: request/response sequencer,
// seed register and output register. Depends on pni_pkg and pni_prng.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------------------
//  req     | in        | req_valid/req_stall  | req_pixel_in, req_starts_buffer,
//          |           |                      | req_ends_buffer
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_pixel_out, rsp_last_out
//  csr     | in        | csr_valid/csr_ready  | csr_noise_seed
//
// A zero-seed request goes straight to finish; a plain noisy byte takes one step
// and a fold; a group leader steps first for the gate and is skipped or noised;
// a buffer start first runs WARMUP_STEPS warm-up steps. Requests are taken only in
// idle, after the result loads; the single xorshift step unit does one step a cycle.
// Reset (synchronous, active high) clears the seed, generator words and group count.
// A stalled result holds the sequencer in its last state until the output is free.

module prng_pixel_noise_injector #(
   parameter int WARMUP_STEPS = pni_pkg::WarmupStepsDefault
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel_in,
   input  logic        req_starts_buffer,
   input  logic        req_ends_buffer,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_out,
   output logic        rsp_last_out,
   // Configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_noise_seed
);

   localparam int WarmW = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WARM,
      S_GATE,
      S_CHECK,
      S_NOISE,
      S_FOLD,
      S_FINISH
   } state_type;

   state_type                 state_ff,   state_in;
   logic [63:0]               seed_ff,    seed_in;
   logic [2:0]                gpos_ff,    gpos_in;
   logic [WarmW-1:0]          warm_ff,    warm_in;
   logic                      enabled_ff, enabled_in;
   logic                      noisy_ff,   noisy_in;
   logic [7:0]                pixel_ff,   pixel_in;
   logic                      last_ff,    last_in;
   logic [pni_pkg::FoldW-1:0] fold_ff,    fold_in;
   logic                      rvalid_ff,  rvalid_in;
   logic [7:0]                rpixel_ff,  rpixel_in;
   logic                      rlast_ff,   rlast_in;

   pni_pkg::prng_cmd_type     cmd;
   logic [63:0]               draw;
   logic                      req_take;
   logic                      out_free;
   logic [1:0]                residue;
   logic [7:0]                noisy_pixel;

   pni_prng u_prng (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .seed_value (seed_ff),
      .draw       (draw)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rvalid_ff || !rsp_stall;

   // Delta from draw mod 3, saturated to a byte
   always_comb begin
      residue     = pni_pkg::mod3_fold(fold_ff);
      noisy_pixel = pixel_ff;
      if (residue == 2'd0) begin
         if (pixel_ff != 8'h00) noisy_pixel = pixel_ff - 8'd1;
      end else if (residue == 2'd2) begin
         if (pixel_ff != 8'hFF) noisy_pixel = pixel_ff + 8'd1;
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      seed_in    = seed_ff;
      gpos_in    = gpos_ff;
      warm_in    = warm_ff;
      enabled_in = enabled_ff;
      noisy_in   = noisy_ff;
      pixel_in   = pixel_ff;
      last_in    = last_ff;
      fold_in    = fold_ff;
      rvalid_in  = rvalid_ff && rsp_stall;
      rpixel_in  = rpixel_ff;
      rlast_in   = rlast_ff;
      cmd        = '0;

      if (csr_valid && csr_ready) seed_in = csr_noise_seed;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pixel_in   = req_pixel_in;
               last_in    = req_ends_buffer;
               enabled_in = (seed_ff != 64'd0);
               noisy_in   = 1'b0;
               warm_in    = '0;
               if (req_starts_buffer) gpos_in = 3'd0;
               if (seed_ff == 64'd0) begin
                  state_in = S_FINISH;
               end else if (req_starts_buffer) begin
                  cmd.seed = 1'b1;
                  state_in = (WARMUP_STEPS > 0) ? S_WARM : S_GATE;
               end else if (gpos_ff == 3'd0) begin
                  state_in = S_GATE;
               end else begin
                  state_in = S_NOISE;
               end
            end
         end
         S_WARM: begin
            cmd.step = 1'b1;
            warm_in  = warm_ff + WarmW'(1);
            if (warm_ff == WarmW'(WARMUP_STEPS - 1)) state_in = S_GATE;
         end
         S_GATE: begin
            cmd.step = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // Group leader is skipped unless its low draw bits are zero
            if ((draw[2:0] & pni_pkg::GateMask) != 3'd0) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_NOISE;
            end
         end
         S_NOISE: begin
            cmd.step = 1'b1;
            state_in = S_FOLD;
         end
         S_FOLD: begin
            fold_in  = pni_pkg::FoldW'(draw[15:0]) + pni_pkg::FoldW'(draw[31:16])
                     + pni_pkg::FoldW'(draw[47:32]) + pni_pkg::FoldW'(draw[63:48]);
            noisy_in = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               rpixel_in = noisy_ff ? noisy_pixel : pixel_ff;
               rlast_in  = last_ff;
               gpos_in   = gpos_ff + 3'd1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         seed_ff   <= '0;
         gpos_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seed_ff   <= seed_in;
         gpos_ff   <= gpos_in;
         rvalid_ff <= rvalid_in;
      end
      warm_ff    <= warm_in;
      enabled_ff <= enabled_in;
      noisy_ff   <= noisy_in;
      pixel_ff   <= pixel_in;
      last_ff    <= last_in;
      fold_ff    <= fold_in;
      rpixel_ff  <= rpixel_in;
      rlast_ff   <= rlast_in;
   end

   assign rsp_valid     = rvalid_ff;
   assign rsp_pixel_out = rpixel_ff;
   assign rsp_last_out  = rlast_ff;

   // A new result only appears right after the finish state
   assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && !$past(rvalid_ff)) |-> ($past(state_ff) == S_FINISH))
      else $error("result loaded outside finish state");

   // Warm-up counter stays below the step count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WARM) |-> (int'(warm_ff) < WARMUP_STEPS))
      else $error("warm-up counter overrun");

   // Generator only draws noise when the seed was nonzero at acceptance
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NOISE || state_ff == S_GATE || state_ff == S_WARM) |-> enabled_ff)
      else $error("generator stepped with noise disabled");

   // A skipped group leader goes straight to finish with no noise
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && draw[2:0] != 3'd0) |=> (state_ff == S_FINISH && !noisy_ff))
      else $error("skipped group leader received noise");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for prng_pixel_noise_injector: random pixel buffers,
// a xorshift128+ noise predictor and a scoreboard on the response channel.
// Depends on the RTL top level only; needs no files or arguments.

module tb_top;

   localparam logic [63:0] SEED_MIX     = 64'h6A09E667F3BCC908;
   localparam int          WARMUP_DRAWS = 8;
   localparam int          SETTLE_CYCLES = 24;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          PHASE_ITEMS  = 275;
   localparam int          DRAIN_AT     = 900;   // sender waits for all results here
   localparam int          HOLD_AT      = 400;   // receiver holds off here
   localparam int          HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [7:0] pixel;
      logic       first;
      logic       last;
   } pixel_req_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       last;
   } noisy_pixel_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_pixel_in;
   logic        req_starts_buffer;
   logic        req_ends_buffer;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_pixel_out;
   logic        rsp_last_out;
   logic        csr_valid;
   logic        csr_ready;
   logic [63:0] csr_noise_seed;

   prng_pixel_noise_injector DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_in      (req_pixel_in),
      .req_starts_buffer (req_starts_buffer),
      .req_ends_buffer   (req_ends_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_last_out      (rsp_last_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_noise_seed    (csr_noise_seed)
   );

   // Predictor state: seed register copy, generator words, byte index in group
   logic [63:0] seed_copy;
   logic [63:0] gen_word0;
   logic [63:0] gen_word1;
   logic [2:0]  group_pos;

   pixel_req_type   pending_pixels[$];
   noisy_pixel_type expected_pixels[$];

   int  error_count;
   int  requests_sent;
   int  results_seen;
   int  cycle_count;
   int  send_gap;
   int  stall_left;
   int  hold_left;
   bit  quiet_run;
   bit  drain_wait;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One xorshift128+ step; returns the sum of the new words
   function automatic logic [63:0] xs_draw();
      logic [63:0] a;
      logic [63:0] b;
      a = gen_word0;
      b = gen_word1;
      gen_word0 = b;
      a = a ^ (a << 23);
      a = a ^ (a >> 17);
      a = a ^ b;
      a = a ^ (b >> 26);
      gen_word1 = a;
      return gen_word0 + gen_word1;
   endfunction

   // Expected noisy byte for one request, advancing the predictor state
   function automatic noisy_pixel_type predict_noise(input pixel_req_type r);
      noisy_pixel_type res;
      logic [7:0]   p;
      logic         enabled;
      logic         apply;
      logic [63:0]  d;
      logic [1:0]   residue;
      p = r.pixel;
      enabled = (seed_copy != 64'd0);
      apply = enabled;
      if (r.first) begin
         group_pos = 3'd0;
         if (enabled) begin
            gen_word0 = seed_copy;
            gen_word1 = seed_copy ^ SEED_MIX;
            repeat (WARMUP_DRAWS) d = xs_draw();
         end
      end
      // group leader draw decides whether this byte is skipped
      if (enabled && group_pos == 3'd0) begin
         d = xs_draw();
         if (d[2:0] != 3'd0) apply = 1'b0;
      end
      if (apply) begin
         d = xs_draw();
         residue = 2'(d % 64'd3);
         if (residue == 2'd0 && p != 8'd0) p = p - 8'd1;
         else if (residue == 2'd2 && p != 8'd255) p = p + 8'd1;
      end
      group_pos = group_pos + 3'd1;
      res.pixel = p;
      res.last = r.last;
      return res;
   endfunction

   // Request driver: feeds pending pixels, random gaps, one drain pause
   always @(posedge clock) begin : request_driver
      pixel_req_type nxt;
      logic       fired;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         drain_wait = 1'b0;
      end else begin
         fired = req_valid && !req_stall;
         if (fired) begin
            expected_pixels.push_back(predict_noise({req_pixel_in, req_starts_buffer,
                                                     req_ends_buffer}));
            requests_sent++;
            if (requests_sent == DRAIN_AT) drain_wait = 1'b1;
         end
         if (drain_wait && expected_pixels.size() == 0) drain_wait = 1'b0;
         if (!req_valid || fired) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!drain_wait && pending_pixels.size() > 0) begin
               nxt = pending_pixels.pop_front();
               req_pixel_in <= nxt.pixel;
               req_starts_buffer <= nxt.first;
               req_ends_buffer <= nxt.last;
               req_valid <= 1'b1;
               if (!quiet_run && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: scoreboard check and receiver stall pattern
   always @(posedge clock) begin : response_monitor
      noisy_pixel_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               $error("unexpected result: pixel_out %0h last_out %0b",
                      rsp_pixel_out, rsp_last_out);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want.pixel) begin
                  $error("pixel_out: expected %0h, got %0h", want.pixel, rsp_pixel_out);
                  error_count++;
               end
               if (rsp_last_out !== want.last) begin
                  $error("last_out: expected %0b, got %0b", want.last, rsp_last_out);
                  error_count++;
               end
            end
            if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("prng_pixel_noise_injector test failed");
         $finish;
      end
   end

   // Seed register write over the configuration channel
   task automatic write_seed(input logic [63:0] value);
      csr_noise_seed <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      seed_copy = value;
   endtask

   // Wait until every request is sent and every result is back
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(0, 1));
         3: return 8'($urandom_range(254, 255));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void queue_pixel(input logic [7:0] p, input logic s, input logic e);
      pending_pixels.push_back('{pixel: p, first: s, last: e});
   endfunction

   // Mostly well-formed buffers, some stray bytes with random markers
   task automatic queue_random_pixels(input int count);
      int n;
      int len;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 99) < 85) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
               queue_pixel(pick_pixel(), i == 0, i == len - 1);
            n += len;
         end else begin
            queue_pixel(pick_pixel(), 1'($urandom), 1'($urandom));
            n++;
         end
      end
   endtask

   initial begin
      logic [63:0] phase_seeds[6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_in = 8'd0;
      req_starts_buffer = 1'b0;
      req_ends_buffer = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_noise_seed = 64'd0;
      seed_copy = 64'd0;
      gen_word0 = 64'd0;
      gen_word1 = 64'd0;
      group_pos = 3'd0;
      error_count = 0;
      requests_sent = 0;
      results_seen = 0;
      cycle_count = 0;
      quiet_run = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes before any buffer start run from the all-zero generator
      write_seed(64'hFFFF_FFFF_FFFF_FFFF);
      queue_pixel(8'h00, 1'b0, 1'b0);
      queue_pixel(8'hFF, 1'b0, 1'b0);
      // full group of eight, extremes, then a stray byte after the end
      for (int i = 0; i < 8; i++)
         queue_pixel((i % 2) ? 8'hFF : 8'h00, i == 0, i == 7);
      queue_pixel(8'h80, 1'b0, 1'b0);
      // one-byte buffers
      queue_pixel(8'hFF, 1'b1, 1'b1);
      queue_pixel(8'h00, 1'b1, 1'b1);
      wait_drained();

      // Zero seed passes bytes through
      write_seed(64'd0);
      queue_pixel(8'h00, 1'b1, 1'b0);
      queue_pixel(8'hFF, 1'b0, 1'b0);
      queue_pixel(8'h55, 1'b0, 1'b0);
      queue_pixel(8'hAA, 1'b0, 1'b1);
      wait_drained();

      // Seed changed inside a buffer
      write_seed(64'd1);
      queue_pixel(8'h01, 1'b1, 1'b0);
      queue_pixel(8'hFE, 1'b0, 1'b0);
      queue_pixel(8'h7F, 1'b0, 1'b0);
      wait_drained();
      write_seed(64'd0);
      queue_pixel(8'h00, 1'b0, 1'b0);
      queue_pixel(8'hFF, 1'b0, 1'b0);
      wait_drained();
      write_seed(64'h8000_0000_0000_0000);
      queue_pixel(8'h10, 1'b0, 1'b0);
      queue_pixel(8'hEF, 1'b0, 1'b0);
      queue_pixel(8'h00, 1'b0, 1'b1);
      wait_drained();

      // Random phases over several seeds; the last one runs without idling
      phase_seeds[0] = 64'd1;
      phase_seeds[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      phase_seeds[2] = {$urandom, $urandom};
      phase_seeds[3] = 64'd0;
      phase_seeds[4] = SEED_MIX;
      phase_seeds[5] = {$urandom, $urandom};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 5) quiet_run = 1'b1;
         write_seed(phase_seeds[ph]);
         queue_random_pixels(PHASE_ITEMS);
         wait_drained();
      end

      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("prng_pixel_noise_injector test passed");
      end else begin
         if (expected_pixels.size() != 0)
            $error("%0d results never arrived", expected_pixels.size());
         $display("prng_pixel_noise_injector test failed");
      end
      $finish;
   end

endmodule

// File: prng_pixel_noise_injector.f
src/pni_pkg.sv
src/pni_prng.sv
src/prng_pixel_noise_injector.sv
tb/sv/tb_top.sv
